[src/sha_pkg.sv]
// SHA-256 shared types, constants and round functions.
package sha_pkg;

	localparam int unsigned BLK_CNT_W = 55;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_PAD,
		ST_PAD2,
		ST_OUT
	} sha_state_t;

	// what follows the hash update of a compressed block
	typedef enum logic [1:0] {
		NX_IDLE,
		NX_PAD,
		NX_PAD2,
		NX_OUT
	} sha_next_t;

	typedef struct packed {
		logic wr_byte;
		logic ld_pad;
		logic ld_tail;
		logic shift;
	} sha_buf_ctl_t;

	typedef struct packed {
		logic load_vars;
		logic do_round;
		logic add_hash;
		logic init_hash;
	} sha_core_ctl_t;

	function automatic logic [31:0] sha_iv(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sha_k(input logic [5:0] t);
		logic [31:0] r;
		case (t)
			6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
			6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
			6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
			6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sha_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] sha_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic logic [31:0] sha_big0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] sha_big1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

endpackage

[src/sha_msg_buf.sv]
// Block buffer: byte fill, padding load and the rolling message schedule.
module sha_msg_buf (
	input  logic                          clk,
	input  sha_pkg::sha_buf_ctl_t         bctl,
	input  logic [7:0]                    data_byte,
	input  logic [5:0]                    fill,
	input  logic [sha_pkg::BLK_CNT_W-1:0] blk_cnt,
	output logic [31:0]                   w_t
);
	import sha_pkg::*;

	logic [31:0] w_q [16];
	logic [31:0] pad_w [16];
	logic [31:0] w_new;
	logic [63:0] bit_len;
	logic [4:0]  lane_off;

	// message length in bits; completed blocks leave the low nine bits zero
	assign bit_len  = {blk_cnt, fill, 3'b000};
	assign lane_off = {~fill[1:0], 3'b000};
	assign w_t      = w_q[0];
	assign w_new    = w_q[0] + sha_sig0(w_q[1]) + w_q[9] + sha_sig1(w_q[14]);

	always_comb begin
		for (int i = 0; i < 64; i++) begin
			logic [7:0] b;
			b = 8'h00;
			if (bctl.ld_tail) begin
				if (i >= 56) begin
					b = bit_len[8*(63-i) +: 8];
				end
			end else begin
				if (7'(i) < {1'b0, fill}) begin
					b = w_q[i/4][8*(3-(i%4)) +: 8];
				end else if (7'(i) == {1'b0, fill}) begin
					b = 8'h80;
				end else if (i >= 56 && fill < 6'd56) begin
					b = bit_len[8*(63-i) +: 8];
				end
			end
			pad_w[i/4][8*(3-(i%4)) +: 8] = b;
		end
	end

	always_ff @(posedge clk) begin
		if (bctl.shift) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end else if (bctl.wr_byte) begin
			w_q[fill[5:2]][lane_off +: 8] <= data_byte;
		end else if (bctl.ld_pad || bctl.ld_tail) begin
			w_q <= pad_w;
		end
	end

endmodule

[src/sha_round_core.sv]
// Compression round unit with working variables and hash state.
module sha_round_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha_pkg::sha_core_ctl_t cctl,
	input  logic [31:0]            w_t,
	input  logic [5:0]             rnd,
	input  logic [2:0]             rd_idx,
	output logic [31:0]            rd_word
);
	import sha_pkg::*;

	logic [31:0] hash_q [8];
	logic [31:0] v_q [8];
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	assign ch      = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj     = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1      = v_q[7] + sha_big1(v_q[4]) + ch + sha_k(rnd) + w_t;
	assign t2      = sha_big0(v_q[0]) + maj;
	assign rd_word = hash_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= sha_iv(3'(i));
			end
		end else if (cctl.init_hash) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= sha_iv(3'(i));
			end
		end else if (cctl.add_hash) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + v_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cctl.load_vars) begin
			v_q <= hash_q;
		end else if (cctl.do_round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

[src/sha256_message_hasher_unit.sv]
// SHA-256 byte-stream hasher top level: sequencer, counters and digest output.
// Usage: send one beat per message byte (has_byte=1); set end_of_message on
// the last byte, or send a beat with has_byte=0 and end_of_message=1. A byte
// beat that does not complete a 64-byte block and does not end the message
// leaves the block ready again in the next cycle. The beat that completes a
// block also loads the round unit, then keeps the block busy for the rounds,
// one round per cycle through a single shared round unit, and one hash
// update. On the end of a message a padding step, which also loads the round
// unit, is followed by 64 rounds and one hash update, or by two such blocks
// when 56 or more bytes of the last block are filled, and then eight digest
// beats, word 0 (most significant) first, with last_word on word 7. The
// output side may stall as long as it likes; input is not taken until the
// eighth digest beat is taken. After that the hash state is back at its
// initial value and the next byte starts a new message. The bit length
// wraps modulo 2^64.
module sha256_message_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  word_index,
	output logic [31:0] digest_word,
	output logic        last_word
);
	import sha_pkg::*;

	sha_state_t            state_q, state_d;
	sha_next_t             nx_q, nx_d;
	logic [5:0]            rnd_q, rnd_d;
	logic [5:0]            fill_q, fill_d;
	logic [BLK_CNT_W-1:0]  blk_q, blk_d;
	logic [2:0]            idx_q, idx_d;
	sha_buf_ctl_t          bctl;
	sha_core_ctl_t         cctl;
	logic [31:0]           w_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nx_q    <= NX_IDLE;
			rnd_q   <= '0;
			fill_q  <= '0;
			blk_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			nx_q    <= nx_d;
			rnd_q   <= rnd_d;
			fill_q  <= fill_d;
			blk_q   <= blk_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		nx_d      = nx_q;
		rnd_d     = rnd_q;
		fill_d    = fill_q;
		blk_d     = blk_q;
		idx_d     = idx_q;
		bctl      = '0;
		cctl      = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (has_byte) begin
						bctl.wr_byte = 1'b1;
						if (fill_q == 6'd63) begin
							// block full: compress before any padding
							cctl.load_vars = 1'b1;
							rnd_d          = '0;
							state_d        = ST_ROUND;
							nx_d           = end_of_message ? NX_PAD : NX_IDLE;
						end else begin
							fill_d = fill_q + 6'd1;
							if (end_of_message) begin
								state_d = ST_PAD;
							end
						end
					end else if (end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				bctl.ld_pad    = 1'b1;
				cctl.load_vars = 1'b1;
				rnd_d          = '0;
				state_d        = ST_ROUND;
				// no room for the length field: it goes in an extra block
				nx_d           = (fill_q < 6'd56) ? NX_OUT : NX_PAD2;
			end
			ST_PAD2: begin
				bctl.ld_tail   = 1'b1;
				cctl.load_vars = 1'b1;
				rnd_d          = '0;
				state_d        = ST_ROUND;
				nx_d           = NX_OUT;
			end
			ST_ROUND: begin
				cctl.do_round = 1'b1;
				bctl.shift    = 1'b1;
				rnd_d         = rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				cctl.add_hash = 1'b1;
				case (nx_q)
					NX_IDLE: begin
						fill_d  = '0;
						blk_d   = blk_q + BLK_CNT_W'(1);
						state_d = ST_IDLE;
					end
					NX_PAD: begin
						fill_d  = '0;
						blk_d   = blk_q + BLK_CNT_W'(1);
						state_d = ST_PAD;
					end
					NX_PAD2: begin
						state_d = ST_PAD2;
					end
					default: begin
						idx_d   = '0;
						state_d = ST_OUT;
					end
				endcase
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (idx_q == 3'd7) begin
						// digest delivered: restart for the next message
						cctl.init_hash = 1'b1;
						fill_d         = '0;
						blk_d          = '0;
						idx_d          = '0;
						state_d        = ST_IDLE;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	sha_msg_buf u_buf (
		.clk       (clk),
		.bctl      (bctl),
		.data_byte (data_byte),
		.fill      (fill_q),
		.blk_cnt   (blk_q),
		.w_t       (w_t)
	);

	sha_round_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cctl    (cctl),
		.w_t     (w_t),
		.rnd     (rnd_q),
		.rd_idx  (idx_q),
		.rd_word (digest_word)
	);

	assign word_index = idx_q;
	assign last_word  = (idx_q == 3'd7);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while digest beats pending");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_word) |=> (in_ready && !out_valid))
		else $error("no restart after final digest beat");

	a_round_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_FINAL))
		else $error("round sequence did not end after 64 rounds");

	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL && nx_q == NX_OUT) |=> (out_valid && word_index == 3'd0))
		else $error("digest output does not start at word 0");
`endif

endmodule

[tb/sv/sha256_message_hasher_unit_tb.sv]
// Self-checking testbench for the SHA-256 byte-stream hasher top level.
`timescale 1ns / 100ps

module sha256_message_hasher_unit_tb;

	// Watchdog: cycles with no beat on either side. The slowest legal gap
	// covers block fill, padding, two compressions and stalls.
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// Quiet cycles after the last digest beat before the verdict.
	localparam int unsigned TAIL_CYCLES    = 150;
	localparam int unsigned RAND_TARGET    = 205;
	localparam int unsigned CALM_ITEMS     = 40;
	localparam int unsigned MAX_REPORTS    = 10;
	localparam int unsigned DIR_ROWS       = 16;

	// Well-known digests: empty string and "abc".
	localparam logic [255:0] EMPTY_DIGEST =
		256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
	localparam logic [255:0] ABC_DIGEST =
		256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;
	localparam logic [255:0] NO_DIGEST = '0;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// One digest beat as the output side should carry it.
	typedef struct packed {
		logic [2:0]  idx;
		logic [31:0] word;
		logic        is_last;
	} digest_beat_t;

	// One directed input beat; known marks a digest typed in by hand.
	typedef struct packed {
		logic [7:0]   dbyte;
		logic         has_b;
		logic         eom;
		logic         known;
		logic [255:0] digest;
	} stim_row_t;

	// Directed beats, walked in order right after reset.
	stim_row_t dir_table [DIR_ROWS] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message right after reset
		'{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // again: data ignored without has_byte
		'{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'h5a, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // no byte, no end: must be ignored
		'{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},    // last byte and end in one beat
		'{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
		'{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},     // one-byte message of all ones
		'{8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'h7f, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'h55, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'haa, 1'b0, 1'b0, 1'b0, NO_DIGEST},
		'{8'haa, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'h01, 1'b0, 1'b1, 1'b0, NO_DIGEST}      // end-only beat closes the message
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        end_of_message;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  word_index;
	logic [31:0] digest_word;
	logic        last_word;

	// Hash state mirror
	logic [31:0]  hash_state [8];
	logic [7:0]   block_buf [64];
	int unsigned  block_fill;
	logic [63:0]  bits_hashed;

	digest_beat_t pending_digest_words [$];
	int unsigned  err_count;
	int unsigned  idle_cycles;
	// set near the end: no gaps and no stalls from here on
	bit           calm;

	sha256_message_hasher_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.word_index     (word_index),
		.digest_word    (digest_word),
		.last_word      (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic restart_hash();
		for (int i = 0; i < 8; i++)
			hash_state[i] = INIT_HASH[i];
		for (int i = 0; i < 64; i++)
			block_buf[i] = 8'h00;
		block_fill  = 0;
		bits_hashed = 64'd0;
	endtask

	// One 64-round compression of block_buf into hash_state.
	task automatic compress_block_buf();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2, ch, mj;
		for (int t = 0; t < 16; t++)
			w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = rotr32(w[t-15], 7) ^ rotr32(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr32(w[t-2], 17) ^ rotr32(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int t = 0; t < 64; t++) begin
			s1 = rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25);
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1 = v[7] + s1 + ch + ROUND_CONST[t] + w[t];
			s0 = rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22);
			mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t2 = s0 + mj;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] = hash_state[i] + v[i];
	endtask

	// Advance the mirror by one accepted beat. On a message end, done is set
	// and dig holds the final hash, word 0 in the top bits.
	task automatic sha256_absorb(input logic [7:0] b, input logic hb, input logic eom,
			output bit done, output logic [255:0] dig);
		int unsigned pos;
		logic [63:0] total;
		done = 1'b0;
		dig  = '0;
		if (hb) begin
			block_buf[block_fill] = b;
			block_fill++;
			if (block_fill == 64) begin
				compress_block_buf();
				bits_hashed = bits_hashed + 64'd512;
				block_fill  = 0;
			end
		end
		if (eom) begin
			total = bits_hashed + 64'(block_fill) * 64'd8;
			pos = block_fill;
			block_buf[pos] = 8'h80;
			pos++;
			// no room for the length: pad out and compress an extra block
			if (pos > 56) begin
				while (pos < 64) begin
					block_buf[pos] = 8'h00;
					pos++;
				end
				compress_block_buf();
				pos = 0;
			end
			while (pos < 56) begin
				block_buf[pos] = 8'h00;
				pos++;
			end
			for (int j = 0; j < 8; j++)
				block_buf[56+j] = total[63-8*j -: 8];
			compress_block_buf();
			dig  = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
				hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
			done = 1'b1;
			restart_hash();
		end
	endtask

	// Present one beat, wait for the handshake, then queue what it produces.
	// A typed digest, if given, replaces the predicted one.
	task automatic send_beat(input logic [7:0] b, input logic hb, input logic eom,
			input logic known, input logic [255:0] known_digest);
		bit done;
		logic [255:0] dig;
		digest_beat_t exp_beat;
		// random sender gap
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= b;
		has_byte       <= hb;
		end_of_message <= eom;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sha256_absorb(b, hb, eom, done, dig);
		if (done) begin
			if (known)
				dig = known_digest;
			for (int j = 0; j < 8; j++) begin
				exp_beat.idx     = 3'(j);
				exp_beat.word    = dig[255-32*j -: 32];
				exp_beat.is_last = (j == 7);
				pending_digest_words.push_back(exp_beat);
			end
		end
	endtask

	task automatic wait_digest_drain();
		while (pending_digest_words.size() != 0)
			@(posedge clk);
	endtask

	// Compare one accepted digest beat with the oldest expectation.
	task automatic check_digest_beat();
		digest_beat_t exp_beat;
		if (pending_digest_words.size() == 0) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("unexpected digest beat: idx %0d word %08h last %0b",
					word_index, digest_word, last_word);
		end else begin
			exp_beat = pending_digest_words.pop_front();
			if (exp_beat.idx !== word_index || exp_beat.word !== digest_word ||
					exp_beat.is_last !== last_word) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("digest mismatch (exp/got): idx %0d/%0d %08h/%08h last %0b/%0b",
						exp_beat.idx, word_index, exp_beat.word, digest_word,
						exp_beat.is_last, last_word);
			end
		end
	endtask

	// Output side: check accepted beats and stall in random bursts.
	int unsigned stall_left;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready)
				check_digest_beat();
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: no beat on either side for too long means a hang.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int unsigned rand_items;
		int unsigned msg_n;
		int unsigned msg_len;
		bit          end_on_byte;
		calm           = 1'b0;
		rand_items     = 0;
		msg_n          = 0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		data_byte      = 8'h00;
		has_byte       = 1'b0;
		end_of_message = 1'b0;
		restart_hash();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty message, "abc", field extremes, ignored beats.
		for (int r = 0; r < DIR_ROWS; r++)
			send_beat(dir_table[r].dbyte, dir_table[r].has_b, dir_table[r].eom,
				dir_table[r].known, dir_table[r].digest);

		// Hold off until every digest is out, then resume with a full pipe.
		in_valid <= 1'b0;
		wait_digest_drain();

		// Random messages. The first three hit the padding edges: a tail of
		// 56..63 bytes (length spills into a second block), a full block plus
		// a short tail, and a 55-byte tail (length just fits). Later ones are
		// mostly short, now and then near a block.
		while (rand_items < RAND_TARGET) begin
			case (msg_n)
				0: msg_len = $urandom_range(56, 63);
				1: msg_len = $urandom_range(64, 72);
				2: msg_len = 55;
				default: msg_len = ($urandom_range(0, 7) == 0) ?
					$urandom_range(50, 66) : $urandom_range(0, 12);
			endcase
			end_on_byte = (msg_len > 0) && ($urandom_range(0, 1) == 1);
			for (int i = 0; i < msg_len; i++) begin
				// stray beat with neither byte nor end
				if ($urandom_range(0, 9) == 0) begin
					send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NO_DIGEST);
					rand_items++;
				end
				send_beat(8'($urandom_range(0, 255)), 1'b1,
					end_on_byte && (i == msg_len - 1), 1'b0, NO_DIGEST);
				rand_items++;
			end
			if (!end_on_byte) begin
				send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
				rand_items++;
			end
			msg_n++;
			if (rand_items + CALM_ITEMS >= RAND_TARGET)
				calm = 1'b1;
		end

		in_valid <= 1'b0;
		wait_digest_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0 && pending_digest_words.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
